/* sv/smm_pkg.sv */
// Shared types, codes and small lookup functions of the square matrix multiplier.
package smm_pkg;

    // Item codes
    localparam logic [1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    // Fixed field widths
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 35;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int CNT_W  = 7;
    localparam int RCP_W  = 10;

    // Reciprocal scale: floor(n * recip(d) >> RECIP_SHIFT) == n / d for n < 64, d <= 8
    localparam int RECIP_SHIFT = 9;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [DIM_W-1:0]         t_dim;
    typedef logic [CNT_W-1:0]         t_cnt;

    // Input word
    typedef struct packed {
        logic [1:0] mode;
        t_elem      element_value;
    } t_in_item;

    // Result word
    typedef struct packed {
        t_acc product_value;
        t_idx row_index;
        t_idx col_index;
        logic last_result;
    } t_result;

    // Control travelling with one multiply-accumulate step
    typedef struct packed {
        logic first;
        logic last;
        t_idx row;
        t_idx col;
        logic final_elem;
    } t_mac_tag;

    // ceil(2^RECIP_SHIFT / d)
    function automatic logic [RCP_W-1:0] recip(input t_dim d);
        logic [RCP_W-1:0] r;
        case (d)
            4'd2:    r = 10'd256;
            4'd3:    r = 10'd171;
            4'd4:    r = 10'd128;
            4'd5:    r = 10'd103;
            4'd6:    r = 10'd86;
            4'd7:    r = 10'd74;
            4'd8:    r = 10'd64;
            default: r = 10'd512;
        endcase
        return r;
    endfunction

    // d squared, for the load limit
    function automatic t_cnt dim_sq(input t_dim d);
        t_cnt s;
        case (d)
            4'd2:    s = 7'd4;
            4'd3:    s = 7'd9;
            4'd4:    s = 7'd16;
            4'd5:    s = 7'd25;
            4'd6:    s = 7'd36;
            4'd7:    s = 7'd49;
            4'd8:    s = 7'd64;
            default: s = 7'd1;
        endcase
        return s;
    endfunction

endpackage

/* sv/smm_ram.sv */
// Generic single write, single read port RAM with registered read data.
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/smm_mac.sv */
// Shared multiply-accumulate unit: registered product, then registered accumulator.
module smm_mac (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  smm_pkg::t_mac_tag i_tag,
    input  smm_pkg::t_elem  i_a,
    input  smm_pkg::t_elem  i_b,
    output logic            o_done,
    output smm_pkg::t_acc   o_sum,
    output smm_pkg::t_mac_tag o_tag
);

    logic              r_p_vld;
    smm_pkg::t_mac_tag r_p_tag;
    smm_pkg::t_prod    r_prod;
    smm_pkg::t_acc     r_acc;
    smm_pkg::t_acc     n_acc;
    smm_pkg::t_mac_tag r_tag;
    logic              r_done;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_vld;
        end
        r_p_tag <= i_tag;
        r_prod  <= smm_pkg::t_prod'(i_a) * smm_pkg::t_prod'(i_b);
    end

    // accumulate: restart on the first term of a dot product
    always_comb begin
        if (r_p_tag.first) begin
            n_acc = smm_pkg::t_acc'(r_prod);
        end else begin
            n_acc = r_acc + smm_pkg::t_acc'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_p_vld && r_p_tag.last;
        end
        if (r_p_vld) begin
            r_acc <= n_acc;
            r_tag <= r_p_tag;
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;
    assign o_tag  = r_tag;

endmodule

/* sv/square_matrix_multiply_core.sv */
// Square matrix multiplier top level: element stores, load logic and compute sequencer.
//
// Load items (A or B, row-major) are taken one per cycle while busy is low and never raise busy.
// A compute item raises busy and streams C = A x B out row-major, one word per
// strobe on o_res_valid, with the final element flagged. All dim^3 products run
// through one multiply-accumulate unit, one product per cycle; busy falls once the
// final element has come out. The receiver cannot stall: each result is shown for
// exactly one cycle. The dimension register may be written only while busy is low.
module square_matrix_multiply_core #(
    parameter int MAX_DIM = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  smm_pkg::t_in_item  i_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  smm_pkg::t_dim      i_cfg_data,
    output logic               o_res_valid,
    output smm_pkg::t_result   o_res
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} t_state;

    t_state              r_state, n_state;
    smm_pkg::t_dim       r_dim;
    smm_pkg::t_cnt       r_cnt_a, n_cnt_a;
    smm_pkg::t_cnt       r_cnt_b, n_cnt_b;
    logic [IW-1:0]       r_row, n_row;
    logic [IW-1:0]       r_col, n_col;
    logic [IW-1:0]       r_k, n_k;
    logic                r_s1_vld;
    smm_pkg::t_mac_tag   r_s1_tag;

    smm_pkg::t_dim       eff_dim;
    smm_pkg::t_dim       dim_m1;
    logic                accept;
    logic                k_end, c_end, r_end;
    logic                issue;
    smm_pkg::t_mac_tag   issue_tag;
    smm_pkg::t_cnt       ld_cnt;
    logic [16:0]         ld_qprod;
    smm_pkg::t_idx       ld_q;
    smm_pkg::t_cnt       ld_qd;
    smm_pkg::t_idx       ld_rem;
    logic [AW-1:0]       ld_addr;
    logic                we_a, we_b;
    logic [AW-1:0]       rd_addr_a, rd_addr_b;
    logic [smm_pkg::ELEM_W-1:0] rd_a, rd_b;
    logic                mac_done;
    smm_pkg::t_acc       mac_sum;
    smm_pkg::t_mac_tag   mac_tag;

    // dimension in force: zero acts as one, large values clamp
    always_comb begin
        if (r_dim == '0) begin
            eff_dim = smm_pkg::t_dim'(1);
        end else if (r_dim > smm_pkg::t_dim'(MAX_DIM)) begin
            eff_dim = smm_pkg::t_dim'(MAX_DIM);
        end else begin
            eff_dim = r_dim;
        end
    end
    assign dim_m1 = eff_dim - smm_pkg::t_dim'(1);

    assign accept = start && !busy;

    // load position: row = n / d by reciprocal multiply, column = n - row * d
    assign ld_cnt   = (i_item.mode == smm_pkg::MODE_LOAD_A) ? r_cnt_a : r_cnt_b;
    assign ld_qprod = 17'(ld_cnt) * 17'(smm_pkg::recip(eff_dim));
    assign ld_q     = smm_pkg::t_idx'(ld_qprod >> smm_pkg::RECIP_SHIFT);
    assign ld_qd    = smm_pkg::t_cnt'(ld_q) * smm_pkg::t_cnt'(eff_dim);
    assign ld_rem   = smm_pkg::t_idx'(ld_cnt - ld_qd);
    assign ld_addr  = {ld_q[IW-1:0], ld_rem[IW-1:0]};

    assign we_a = accept && (i_item.mode == smm_pkg::MODE_LOAD_A)
                  && (r_cnt_a < smm_pkg::dim_sq(eff_dim));
    assign we_b = accept && (i_item.mode == smm_pkg::MODE_LOAD_B)
                  && (r_cnt_b < smm_pkg::dim_sq(eff_dim));

    // sequencer position
    assign k_end = (smm_pkg::t_dim'(r_k) == dim_m1);
    assign c_end = (smm_pkg::t_dim'(r_col) == dim_m1);
    assign r_end = (smm_pkg::t_dim'(r_row) == dim_m1);
    assign issue = (r_state == ST_RUN);

    assign issue_tag.first      = (r_k == '0);
    assign issue_tag.last       = k_end;
    assign issue_tag.row        = smm_pkg::t_idx'(r_row);
    assign issue_tag.col        = smm_pkg::t_idx'(r_col);
    assign issue_tag.final_elem = k_end && c_end && r_end;

    assign rd_addr_a = {r_row, r_k};
    assign rd_addr_b = {r_k, r_col};

    // next state, counters and load counts
    always_comb begin
        n_state = r_state;
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (we_a) begin
                    n_cnt_a = r_cnt_a + smm_pkg::t_cnt'(1);
                end
                if (we_b) begin
                    n_cnt_b = r_cnt_b + smm_pkg::t_cnt'(1);
                end
                if (accept && (i_item.mode == smm_pkg::MODE_COMPUTE)) begin
                    n_state = ST_RUN;
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                n_k = r_k + IW'(1);
                if (k_end) begin
                    n_k   = '0;
                    n_col = r_col + IW'(1);
                    if (c_end) begin
                        n_col = '0;
                        n_row = r_row + IW'(1);
                        if (r_end) begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (mac_done && mac_tag.final_elem) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state, configuration and read-stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_dim    <= smm_pkg::t_dim'(8);
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_k      <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_row    <= n_row;
            r_col    <= n_col;
            r_k      <= n_k;
            r_s1_vld <= issue;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dim <= i_cfg_data;
            end
        end
        r_s1_tag <= issue_tag;
    end

    // element stores
    smm_ram #(
        .WIDTH (smm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (ld_addr),
        .i_wdata (i_item.element_value),
        .i_raddr (rd_addr_a),
        .o_rdata (rd_a)
    );

    smm_ram #(
        .WIDTH (smm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (ld_addr),
        .i_wdata (i_item.element_value),
        .i_raddr (rd_addr_b),
        .o_rdata (rd_b)
    );

    // shared multiply-accumulate
    smm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s1_vld),
        .i_tag   (r_s1_tag),
        .i_a     ($signed(rd_a)),
        .i_b     ($signed(rd_b)),
        .o_done  (mac_done),
        .o_sum   (mac_sum),
        .o_tag   (mac_tag)
    );

    // result word straight from the accumulator register
    assign o_res_valid         = mac_done;
    assign o_res.product_value = mac_sum;
    assign o_res.row_index     = mac_tag.row;
    assign o_res.col_index     = mac_tag.col;
    assign o_res.last_result   = mac_tag.final_elem;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;

`ifndef SYNTH
    // results only come out while a compute is in progress
    a_res_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy)
        else $error("result word outside a compute");

    // a compute item always raises busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.mode == smm_pkg::MODE_COMPUTE) |=> busy)
        else $error("compute accepted but block not busy");

    // the final element ends the compute
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last_result) |=> !busy)
        else $error("busy held after final element");

    // load counts never pass the store size
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= smm_pkg::t_cnt'(MAX_DIM * MAX_DIM))
        && (r_cnt_b <= smm_pkg::t_cnt'(MAX_DIM * MAX_DIM)))
        else $error("load count beyond store size");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the square matrix multiplier core.
`timescale 1ns / 100ps

module testbench;
    import smm_pkg::*;

    localparam int N_MAX         = 8;
    localparam int ITEM_TARGET   = 310;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_in_item i_item;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_dim     i_cfg_data;
    logic     o_res_valid;
    t_result  o_res;

    // Predicted state of the core
    t_elem       mat_a [0:N_MAX*N_MAX-1];
    t_elem       mat_b [0:N_MAX*N_MAX-1];
    bit [63:0]   wr_a;
    bit [63:0]   wr_b;
    int          loads_a;
    int          loads_b;
    t_dim        dim_reg;

    t_result     product_q [$];
    t_result     exp_word;
    int          error_count;
    int          n_items;
    int          cycle_count;
    bit          idle_on;

    square_matrix_multiply_core #(.MAX_DIM(N_MAX)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, product_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Dimension actually used for a register value
    function automatic int dim_of(input t_dim v);
        if (v == 0)
            return 1;
        if (v > N_MAX)
            return N_MAX;
        return int'(v);
    endfunction

    // True if loading up to d*d from count leaves no unwritten entry in the d x d corner
    function automatic bit fill_ok(input bit [63:0] written, input int d, input int count);
        bit [63:0] seen;
        int        n;
        int        r;
        int        c;
        seen = written;
        for (n = count; n < d * d; n++)
            seen[(n / d) * N_MAX + n % d] = 1'b1;
        for (r = 0; r < d; r++)
            for (c = 0; c < d; c++)
                if (!seen[r * N_MAX + c])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Update the predicted state for one accepted word and queue the products it causes
    function automatic void predict_word(input t_in_item w);
        int      d;
        int      r;
        int      c;
        int      j;
        longint  acc;
        t_result res;
        d = dim_of(dim_reg);
        case (w.mode)
            MODE_LOAD_A: begin
                if (loads_a < d * d) begin
                    mat_a[(loads_a / d) * N_MAX + loads_a % d] = w.element_value;
                    wr_a[(loads_a / d) * N_MAX + loads_a % d] = 1'b1;
                    loads_a++;
                end
            end
            MODE_LOAD_B: begin
                if (loads_b < d * d) begin
                    mat_b[(loads_b / d) * N_MAX + loads_b % d] = w.element_value;
                    wr_b[(loads_b / d) * N_MAX + loads_b % d] = 1'b1;
                    loads_b++;
                end
            end
            MODE_COMPUTE: begin
                for (r = 0; r < d; r++) begin
                    for (c = 0; c < d; c++) begin
                        acc = 0;
                        for (j = 0; j < d; j++)
                            acc += longint'(mat_a[r * N_MAX + j]) * longint'(mat_b[j * N_MAX + c]);
                        res.product_value = acc[ACC_W-1:0];
                        res.row_index     = t_idx'(r);
                        res.col_index     = t_idx'(c);
                        res.last_result   = (r == d - 1) && (c == d - 1);
                        product_q.push_back(res);
                    end
                end
                // counters rewind, stored entries stay
                loads_a = 0;
                loads_b = 0;
            end
            default: ;
        endcase
    endfunction

    // Element value, either fully random or one of the corner values
    function automatic t_elem pick_elem(input bit extreme);
        if (!extreme)
            return t_elem'($urandom_range(16'hFFFF, 0));
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'shFFFF;
            3:       return 16'sh0001;
            default: return 16'sh0000;
        endcase
    endfunction

    // Send one word; called and returns at a falling edge, leaves start high
    task automatic send_word(input logic [1:0] mode, input t_elem value);
        t_in_item w;
        w.mode          = mode;
        w.element_value = value;
        while (idle_on && $urandom_range(99) < 27) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        predict_word(w);
        n_items++;
        @(negedge i_clk);
    endtask

    // Hold off until every expected word has come and the core has gone quiet
    task automatic wait_idle();
        start <= 1'b0;
        while (product_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the dimension register; only called while idle
    task automatic write_dim(input t_dim v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        dim_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One load-and-compute sequence at the current dimension, well-formed or not
    task automatic run_set();
        int d;
        int kind;
        int na;
        int nb;
        bit extreme;
        bit complete;
        d        = dim_of(dim_reg);
        kind     = $urandom_range(9);
        extreme  = ($urandom_range(4) == 0);
        complete = fill_ok(wr_a, d, d * d) && fill_ok(wr_b, d, d * d);
        // large sizes only top up a few entries over old data
        if (d >= 6 && complete && kind != 9)
            kind = 8;
        if (kind == 9) begin
            // broken sequence: partial loads and noise, no compute
            repeat ($urandom_range(1, d * d)) begin
                if ($urandom_range(3) == 0)
                    send_word(MODE_UNUSED, pick_elem(1'b0));
                else
                    send_word($urandom_range(1) ? MODE_LOAD_B : MODE_LOAD_A, pick_elem(extreme));
            end
        end else if (kind == 8 && complete) begin
            // few loads over existing entries, then compute
            repeat ($urandom_range(0, 2 * d))
                send_word($urandom_range(1) ? MODE_LOAD_B : MODE_LOAD_A, pick_elem(extreme));
            send_word(MODE_COMPUTE, pick_elem(1'b0));
        end else begin
            na = (loads_a < d * d) ? d * d - loads_a : 0;
            nb = (loads_b < d * d) ? d * d - loads_b : 0;
            while (na > 0 || nb > 0) begin
                if (kind == 6 && $urandom_range(5) == 0) begin
                    send_word(MODE_UNUSED, pick_elem(1'b0));
                end else if (nb == 0 || (na > 0 && $urandom_range(1))) begin
                    send_word(MODE_LOAD_A, pick_elem(extreme));
                    na--;
                end else begin
                    send_word(MODE_LOAD_B, pick_elem(extreme));
                    nb--;
                end
            end
            // loads past the full matrix are dropped
            if (kind == 6)
                repeat ($urandom_range(1, 2))
                    send_word($urandom_range(1) ? MODE_LOAD_B : MODE_LOAD_A, pick_elem(1'b0));
            send_word(MODE_COMPUTE, pick_elem(1'b0));
        end
    endtask

    // Size one, corner values, extra loads, unused mode and a zero dimension
    task automatic test_single_element();
        wait_idle();
        write_dim(4'd1);
        send_word(MODE_LOAD_A, 16'sh8000);
        send_word(MODE_LOAD_B, 16'sh8000);
        send_word(MODE_COMPUTE, 16'sh0000);
        send_word(MODE_LOAD_A, 16'sh7FFF);
        send_word(MODE_LOAD_A, 16'sh1234);
        send_word(MODE_LOAD_B, 16'sh8000);
        send_word(MODE_UNUSED, 16'shFFFF);
        send_word(MODE_COMPUTE, 16'shFFFF);
        wait_idle();
        write_dim(4'd0);
        send_word(MODE_LOAD_A, 16'shFFFF);
        send_word(MODE_LOAD_B, 16'sh0001);
        send_word(MODE_COMPUTE, 16'sh0000);
    endtask

    // Two by two with corner values, then a rewind that reuses kept entries
    task automatic test_corners_dim2();
        wait_idle();
        write_dim(4'd2);
        send_word(MODE_LOAD_A, 16'sh7FFF);
        send_word(MODE_LOAD_B, 16'sh8000);
        send_word(MODE_LOAD_A, 16'sh8000);
        send_word(MODE_LOAD_B, 16'sh8000);
        send_word(MODE_LOAD_A, 16'shFFFF);
        send_word(MODE_LOAD_B, 16'sh7FFF);
        send_word(MODE_LOAD_A, 16'sh0001);
        send_word(MODE_LOAD_B, 16'sh0100);
        send_word(MODE_COMPUTE, 16'sh0000);
        send_word(MODE_LOAD_A, 16'sh0100);
        send_word(MODE_COMPUTE, 16'sh0000);
    endtask

    // Shrinking the dimension part way through loading A
    task automatic test_shrink_mid_load();
        wait_idle();
        write_dim(4'd3);
        repeat (5) send_word(MODE_LOAD_A, pick_elem(1'b0));
        wait_idle();
        write_dim(4'd2);
        send_word(MODE_LOAD_A, 16'sh4321);
        send_word(MODE_COMPUTE, 16'sh0000);
    endtask

    // Full size through an out-of-range value, largest magnitude sums
    task automatic test_full_size();
        wait_idle();
        write_dim(4'd15);
        repeat (N_MAX * N_MAX) send_word(MODE_LOAD_A, 16'sh8000);
        repeat (N_MAX * N_MAX) send_word(MODE_LOAD_B, 16'sh8000);
        send_word(MODE_COMPUTE, 16'sh0000);
        wait_idle();
        write_dim(4'd8);
        send_word(MODE_LOAD_B, 16'sh7FFF);
        send_word(MODE_LOAD_B, 16'sh7FFF);
        send_word(MODE_COMPUTE, 16'sh0000);
    endtask

    // Random dimensions and sequences until the word count is reached
    task automatic test_random_traffic();
        int   phase;
        int   pick;
        t_dim v;
        phase = 0;
        while (n_items < ITEM_TARGET) begin
            wait_idle();
            pick = $urandom_range(99);
            case ($urandom_range(2))
                0:       v = 4'd0;
                1:       v = 4'd9;
                default: v = 4'd15;
            endcase
            if (pick >= 8)
                v = (pick < 25) ? t_dim'($urandom_range(5, 8)) : t_dim'($urandom_range(1, 4));
            // keep the old value if the change would leave a hole that can never be loaded
            if (!(fill_ok(wr_a, dim_of(v), loads_a) && fill_ok(wr_b, dim_of(v), loads_b)))
                v = dim_reg;
            write_dim(v);
            // two phases run back to back with no gaps
            idle_on = !(phase == 2 || phase == 3);
            repeat ($urandom_range(1, 3)) begin
                run_set();
                if ($urandom_range(3) == 0)
                    wait_idle();
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    // Result checker
    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (product_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %p", $time, o_res);
                error_count++;
            end else begin
                exp_word = product_q.pop_front();
                check_field("product_value", exp_word.product_value, o_res.product_value);
                check_field("row_index", exp_word.row_index, o_res.row_index);
                check_field("col_index", exp_word.col_index, o_res.col_index);
                check_field("last_result", exp_word.last_result, o_res.last_result);
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        error_count = 0;
        n_items     = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        wr_a        = '0;
        wr_b        = '0;
        loads_a     = 0;
        loads_b     = 0;
        dim_reg     = 4'd8;
        for (int i = 0; i < N_MAX * N_MAX; i++) begin
            mat_a[i] = '0;
            mat_b[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_single_element();
        test_corners_dim2();
        test_shrink_mid_load();
        test_full_size();
        test_random_traffic();
        wait_idle();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
